// File: rtl/particle_pool_update_macros.svh
// Assertion macros shared by the particle pool RTL.
`ifndef PARTICLE_POOL_UPDATE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ppu_pkg.sv
// Types and constants shared by the particle pool controller, datapath and top level.
`default_nettype none

package ppu_pkg;

    localparam int FRAC      = 16;
    localparam int POS_W     = 32;
    localparam int AGE_W     = 24;
    localparam int DT_W      = 16;
    localparam int SIZE_W    = 16;
    localparam int COL_W     = 32;
    localparam int SPIN_W    = 16;
    localparam int CNT_W     = 7;
    localparam int FAC_W     = 17;
    localparam int MA_W      = 33;
    localparam int MB_W      = 18;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int DIV_STEPS = 2;
    localparam int DIV_CYC   = FRAC / DIV_STEPS;
    localparam int DIV_CNT_W = 4;

    localparam logic MODE_SPAWN = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic [2:0] REG_GRAVITY     = 3'd0;
    localparam logic [2:0] REG_DRAG        = 3'd1;
    localparam logic [2:0] REG_SIZE_START  = 3'd2;
    localparam logic [2:0] REG_SIZE_END    = 3'd3;
    localparam logic [2:0] REG_COLOR_START = 3'd4;
    localparam logic [2:0] REG_COLOR_END   = 3'd5;

    localparam logic [31:0] RST_GRAVITY     = 32'h0000_0000;
    localparam logic [23:0] RST_DRAG        = 24'h00_0000;
    localparam logic [15:0] RST_SIZE_START  = 16'h0100;
    localparam logic [15:0] RST_SIZE_END    = 16'h0000;
    localparam logic [31:0] RST_COLOR_START = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_COLOR_END   = 32'h0000_0000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_GRAV,
        OP_DRAG,
        OP_VX,
        OP_VY,
        OP_VZ,
        OP_PX,
        OP_PY,
        OP_PZ,
        OP_SIZE,
        OP_C0,
        OP_C1,
        OP_C2,
        OP_C3
    } op_t;

    typedef struct packed {
        logic spawn;
        logic tick_start;
        logic slot_clear;
        logic age_step;
        logic slot_next;
        logic emit;
        logic finish;
        op_t  mul_op;
    } ppu_cmd_t;

    typedef struct packed {
        logic slot_alive;
        logic slot_last;
        logic dies;
        logic div_done;
        logic can_emit;
        logic out_free;
    } ppu_stat_t;

    typedef struct packed {
        logic [POS_W-1:0]  gravity_y;
        logic [AGE_W-1:0]  drag_rate;
        logic [SIZE_W-1:0] size_start;
        logic [SIZE_W-1:0] size_end;
        logic [COL_W-1:0]  color_start;
        logic [COL_W-1:0]  color_end;
    } ppu_cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [POS_W-1:0]  pz;
        logic [POS_W-1:0]  vx;
        logic [POS_W-1:0]  vy;
        logic [POS_W-1:0]  vz;
        logic [AGE_W-1:0]  age;
        logic [AGE_W-1:0]  life;
        logic [SPIN_W-1:0] spin;
    } ppu_entry_t;

endpackage

`default_nettype wire

// File: rtl/ppu_ctrl.sv
// Controller state machine that sequences spawns and the per-slot tick walk.
`default_nettype none
`include "particle_pool_update_macros.svh"

module ppu_ctrl
    import ppu_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_mode,
    output logic           s_ready,
    input  wire ppu_stat_t stat,
    output ppu_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_AGE,
        ST_MOTION,
        ST_DIVWAIT,
        ST_MIX,
        ST_EMIT,
        ST_FINISH
    } state_t;

    localparam logic [2:0] PREP_LAST   = 3'd2;
    localparam logic [2:0] MOTION_LAST = 3'd5;
    localparam logic [2:0] MIX_LAST    = 3'd5;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;

    always_comb begin
        cmd        = '0;
        cmd.mul_op = OP_NONE;
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_mode == MODE_TICK) begin
                        cmd.tick_start = 1'b1;
                        cmd.slot_clear = 1'b1;
                        state_next     = ST_PREP;
                        step_next      = '0;
                    end else begin
                        cmd.spawn = 1'b1;
                    end
                end
            end
            ST_PREP: begin
                case (step_reg)
                    3'd0:    cmd.mul_op = OP_GRAV;
                    3'd1:    cmd.mul_op = OP_DRAG;
                    default: cmd.mul_op = OP_NONE;
                endcase
                if (step_reg == PREP_LAST) begin
                    state_next = ST_SCAN;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_SCAN: begin
                if (stat.slot_alive) begin
                    state_next = ST_AGE;
                end else if (stat.slot_last) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.slot_next = 1'b1;
                end
            end
            ST_AGE: begin
                cmd.age_step = 1'b1;
                if (stat.dies) begin
                    if (stat.slot_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.slot_next = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end else begin
                    state_next = ST_MOTION;
                    step_next  = '0;
                end
            end
            ST_MOTION: begin
                // Velocity products first, so that each position product sees the
                // damped velocity.
                case (step_reg)
                    3'd0:    cmd.mul_op = OP_VX;
                    3'd1:    cmd.mul_op = OP_VY;
                    3'd2:    cmd.mul_op = OP_VZ;
                    3'd3:    cmd.mul_op = OP_PX;
                    3'd4:    cmd.mul_op = OP_PY;
                    default: cmd.mul_op = OP_PZ;
                endcase
                if (step_reg == MOTION_LAST) begin
                    state_next = ST_DIVWAIT;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_DIVWAIT: begin
                if (stat.div_done) begin
                    state_next = ST_MIX;
                    step_next  = '0;
                end
            end
            ST_MIX: begin
                case (step_reg)
                    3'd0:    cmd.mul_op = OP_SIZE;
                    3'd1:    cmd.mul_op = OP_C3;
                    3'd2:    cmd.mul_op = OP_C2;
                    3'd3:    cmd.mul_op = OP_C1;
                    3'd4:    cmd.mul_op = OP_C0;
                    default: cmd.mul_op = OP_NONE;
                endcase
                if (step_reg == MIX_LAST) begin
                    state_next = ST_EMIT;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_EMIT: begin
                if (stat.can_emit) begin
                    cmd.emit = 1'b1;
                    if (stat.slot_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.slot_next = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `PPU_ASSERT_NOW(a_emit_room, cmd.emit, stat.can_emit, "survivor pushed with no room")
    `PPU_ASSERT_NOW(a_mix_after_div, cmd.mul_op == OP_SIZE, stat.div_done, "lerp before quotient")
    `PPU_ASSERT_NEXT(a_finish_idle, cmd.finish, s_ready, "not idle after closing transfer")

endmodule

`default_nettype wire

// File: rtl/ppu_dp.sv
// Datapath: particle memory, alive flags, shared multiplier, divider and result registers.
`default_nettype none

module ppu_dp
    import ppu_pkg::*;
#(
    parameter int POOL_DEPTH = 64
)(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ppu_cfg_t          cfg,
    input  wire ppu_cmd_t          cmd,
    output ppu_stat_t              stat,
    input  wire logic [POS_W-1:0]  s_spawn_x,
    input  wire logic [POS_W-1:0]  s_spawn_y,
    input  wire logic [POS_W-1:0]  s_spawn_z,
    input  wire logic [POS_W-1:0]  s_launch_vx,
    input  wire logic [POS_W-1:0]  s_launch_vy,
    input  wire logic [POS_W-1:0]  s_launch_vz,
    input  wire logic [SPIN_W-1:0] s_spin_angle,
    input  wire logic [AGE_W-1:0]  s_life_span,
    input  wire logic [DT_W-1:0]   s_time_step,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [POS_W-1:0]       m_out_x,
    output logic [POS_W-1:0]       m_out_y,
    output logic [POS_W-1:0]       m_out_z,
    output logic [SIZE_W-1:0]      m_out_size,
    output logic [COL_W-1:0]       m_out_color,
    output logic [SPIN_W-1:0]      m_out_spin,
    output logic                   m_last_of_tick,
    output logic                   m_none_alive,
    output logic [CNT_W-1:0]       m_live_total
);

    localparam int SLOT_W = $clog2(POOL_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(POOL_DEPTH - 1);
    localparam logic [FAC_W-1:0]  FAC_ONE   = FAC_W'(1 << FRAC);

    function automatic logic [POS_W-1:0] sat32(input logic [POS_W:0] v);
        logic [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1]) begin
            r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    ppu_entry_t mem [POOL_DEPTH];
    ppu_entry_t rd_reg;
    ppu_entry_t wk_reg, wk_next;

    logic [POOL_DEPTH-1:0] alive_reg;
    logic [SLOT_W-1:0]     next_slot_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [DT_W-1:0]       dt_reg;
    logic [POS_W-1:0]      gv_reg;
    logic [FAC_W-1:0]      fac_reg;

    logic signed [PROD_W-1:0] prod_reg;
    op_t                      prod_op_reg;

    logic [AGE_W-1:0]     rem_reg, rem_next;
    logic [FRAC-1:0]      quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [SIZE_W-1:0] size_reg;
    logic [COL_W-1:0]  col_reg;

    logic [POS_W-1:0]  pend_x_reg, pend_y_reg, pend_z_reg;
    logic [SIZE_W-1:0] pend_size_reg;
    logic [COL_W-1:0]  pend_col_reg;
    logic [SPIN_W-1:0] pend_spin_reg;
    logic              pend_valid_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              m_valid_reg;
    logic [POS_W-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic [SIZE_W-1:0] out_size_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [SPIN_W-1:0] out_spin_reg;
    logic              out_last_reg, out_none_reg;
    logic [CNT_W-1:0]  out_total_reg;

    // Age update and death test on the entry just read.
    logic [AGE_W:0]     age_sum;
    logic [AGE_W-1:0]   age_new;
    logic               dies;
    logic [POS_W-1:0]   vy_grav;
    ppu_entry_t         spawn_entry;
    ppu_entry_t         wr_data;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_sh;
    logic [AGE_W-1:0]         drag_d;
    logic [FAC_W-1:0]         fac_new;
    logic [SIZE_W:0]          size_diff;
    logic [8:0]               byte_diff [4];
    logic                     out_free;

    assign age_sum = {1'b0, rd_reg.age} + {{(AGE_W + 1 - DT_W){1'b0}}, dt_reg};
    assign age_new = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];
    assign dies    = (age_new >= rd_reg.life);
    assign vy_grav = sat32({rd_reg.vy[POS_W-1], rd_reg.vy} + {gv_reg[POS_W-1], gv_reg});

    always_comb begin
        spawn_entry      = '0;
        spawn_entry.px   = s_spawn_x;
        spawn_entry.py   = s_spawn_y;
        spawn_entry.pz   = s_spawn_z;
        spawn_entry.vx   = s_launch_vx;
        spawn_entry.vy   = s_launch_vy;
        spawn_entry.vz   = s_launch_vz;
        spawn_entry.life = s_life_span;
        spawn_entry.spin = s_spin_angle;
    end

    always_comb begin
        wr_en   = cmd.spawn | cmd.emit;
        wr_addr = cmd.spawn ? next_slot_reg : slot_reg;
        wr_data = cmd.spawn ? spawn_entry : wk_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[slot_reg];
    end

    // Shared multiplier operand selection.
    assign size_diff = {1'b0, cfg.size_end} - {1'b0, cfg.size_start};
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            byte_diff[k] = {1'b0, cfg.color_end[k*8 +: 8]} - {1'b0, cfg.color_start[k*8 +: 8]};
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            OP_GRAV: begin
                mul_a = $signed({cfg.gravity_y[POS_W-1], cfg.gravity_y});
                mul_b = $signed({2'b00, dt_reg});
            end
            OP_DRAG: begin
                mul_a = $signed({{(MA_W - AGE_W){1'b0}}, cfg.drag_rate});
                mul_b = $signed({2'b00, dt_reg});
            end
            OP_VX: begin
                mul_a = $signed({wk_reg.vx[POS_W-1], wk_reg.vx});
                mul_b = $signed({1'b0, fac_reg});
            end
            OP_VY: begin
                mul_a = $signed({wk_reg.vy[POS_W-1], wk_reg.vy});
                mul_b = $signed({1'b0, fac_reg});
            end
            OP_VZ: begin
                mul_a = $signed({wk_reg.vz[POS_W-1], wk_reg.vz});
                mul_b = $signed({1'b0, fac_reg});
            end
            OP_PX: begin
                mul_a = $signed({wk_reg.vx[POS_W-1], wk_reg.vx});
                mul_b = $signed({2'b00, dt_reg});
            end
            OP_PY: begin
                mul_a = $signed({wk_reg.vy[POS_W-1], wk_reg.vy});
                mul_b = $signed({2'b00, dt_reg});
            end
            OP_PZ: begin
                mul_a = $signed({wk_reg.vz[POS_W-1], wk_reg.vz});
                mul_b = $signed({2'b00, dt_reg});
            end
            OP_SIZE: begin
                mul_a = $signed({{(MA_W - SIZE_W - 1){size_diff[SIZE_W]}}, size_diff});
                mul_b = $signed({2'b00, quo_reg});
            end
            OP_C0: begin
                mul_a = $signed({{(MA_W - 9){byte_diff[0][8]}}, byte_diff[0]});
                mul_b = $signed({2'b00, quo_reg});
            end
            OP_C1: begin
                mul_a = $signed({{(MA_W - 9){byte_diff[1][8]}}, byte_diff[1]});
                mul_b = $signed({2'b00, quo_reg});
            end
            OP_C2: begin
                mul_a = $signed({{(MA_W - 9){byte_diff[2][8]}}, byte_diff[2]});
                mul_b = $signed({2'b00, quo_reg});
            end
            OP_C3: begin
                mul_a = $signed({{(MA_W - 9){byte_diff[3][8]}}, byte_diff[3]});
                mul_b = $signed({2'b00, quo_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    // Arithmetic shift of a signed product rounds towards minus infinity.
    assign prod_sh = prod_reg >>> FRAC;
    assign drag_d  = prod_reg[AGE_W+FRAC-1:FRAC];
    assign fac_new = (drag_d >= {{(AGE_W - FAC_W){1'b0}}, FAC_ONE}) ? '0
                   : FAC_ONE - drag_d[FAC_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_op_reg <= OP_NONE;
        end else begin
            prod_op_reg <= cmd.mul_op;
        end
        prod_reg <= mul_p;
    end

    // Working copy of the slot under update, and the products it absorbs.
    always_comb begin
        wk_next = wk_reg;
        if (cmd.age_step && !dies) begin
            wk_next     = rd_reg;
            wk_next.age = age_new;
            wk_next.vy  = vy_grav;
        end
        case (prod_op_reg)
            OP_VX:   wk_next.vx = prod_sh[POS_W-1:0];
            OP_VY:   wk_next.vy = prod_sh[POS_W-1:0];
            OP_VZ:   wk_next.vz = prod_sh[POS_W-1:0];
            OP_PX:   wk_next.px = sat32({wk_reg.px[POS_W-1], wk_reg.px} + prod_sh[POS_W:0]);
            OP_PY:   wk_next.py = sat32({wk_reg.py[POS_W-1], wk_reg.py} + prod_sh[POS_W:0]);
            OP_PZ:   wk_next.pz = sat32({wk_reg.pz[POS_W-1], wk_reg.pz} + prod_sh[POS_W:0]);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_start) begin
            dt_reg <= s_time_step;
        end
        wk_reg <= wk_next;
        case (prod_op_reg)
            OP_GRAV: gv_reg    <= prod_sh[POS_W-1:0];
            OP_DRAG: fac_reg   <= fac_new;
            OP_SIZE: size_reg  <= cfg.size_start + prod_sh[SIZE_W-1:0];
            OP_C0:   col_reg[7:0]   <= cfg.color_start[7:0] + prod_sh[7:0];
            OP_C1:   col_reg[15:8]  <= cfg.color_start[15:8] + prod_sh[7:0];
            OP_C2:   col_reg[23:16] <= cfg.color_start[23:16] + prod_sh[7:0];
            OP_C3:   col_reg[31:24] <= cfg.color_start[31:24] + prod_sh[7:0];
            default: ;
        endcase
    end

    // Restoring divider for age/lifetime, two quotient bits per cycle. The
    // partial remainder always stays below the lifetime.
    always_comb begin
        logic [AGE_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int j = 0; j < DIV_STEPS; j++) begin
            trial = {rem_next, 1'b0};
            if (trial >= {1'b0, wk_reg.life}) begin
                trial    = trial - {1'b0, wk_reg.life};
                quo_next = {quo_next[FRAC-2:0], 1'b1};
            end else begin
                quo_next = {quo_next[FRAC-2:0], 1'b0};
            end
            rem_next = trial[AGE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.age_step && !dies) begin
            div_cnt_reg <= DIV_CNT_W'(DIV_CYC);
        end else if (div_cnt_reg != '0) begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
        if (cmd.age_step && !dies) begin
            rem_reg <= age_new;
            quo_reg <= '0;
        end else if (div_cnt_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Slot bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg     <= '0;
            next_slot_reg <= '0;
            slot_reg      <= '0;
        end else begin
            if (cmd.spawn) begin
                alive_reg[next_slot_reg] <= 1'b1;
                next_slot_reg <= (next_slot_reg == SLOT_LAST) ? '0 : next_slot_reg + 1'b1;
            end
            if (cmd.age_step && dies) begin
                alive_reg[slot_reg] <= 1'b0;
            end
            if (cmd.slot_clear) begin
                slot_reg <= '0;
            end else if (cmd.slot_next) begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    // A survivor waits in the pending stage until the next one shows whether
    // it closes the tick.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.tick_start) begin
                pend_valid_reg <= 1'b0;
                cnt_reg        <= '0;
            end else if (cmd.emit) begin
                pend_valid_reg <= 1'b1;
                cnt_reg        <= cnt_reg + 1'b1;
            end else if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.emit && pend_valid_reg) || cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            pend_x_reg    <= wk_reg.px;
            pend_y_reg    <= wk_reg.py;
            pend_z_reg    <= wk_reg.pz;
            pend_size_reg <= size_reg;
            pend_col_reg  <= col_reg;
            pend_spin_reg <= wk_reg.spin;
        end
        if ((cmd.emit && pend_valid_reg) || (cmd.finish && pend_valid_reg)) begin
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_z_reg     <= pend_z_reg;
            out_size_reg  <= pend_size_reg;
            out_col_reg   <= pend_col_reg;
            out_spin_reg  <= pend_spin_reg;
            out_last_reg  <= cmd.finish;
            out_none_reg  <= 1'b0;
            out_total_reg <= cmd.finish ? cnt_reg : '0;
        end else if (cmd.finish) begin
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_size_reg  <= '0;
            out_col_reg   <= '0;
            out_spin_reg  <= '0;
            out_last_reg  <= 1'b1;
            out_none_reg  <= 1'b1;
            out_total_reg <= '0;
        end
    end

    always_comb begin
        stat.slot_alive = alive_reg[slot_reg];
        stat.slot_last  = (slot_reg == SLOT_LAST);
        stat.dies       = dies;
        stat.div_done   = (div_cnt_reg == '0);
        stat.can_emit   = !pend_valid_reg || out_free;
        stat.out_free   = out_free;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_x        = out_x_reg;
    assign m_out_y        = out_y_reg;
    assign m_out_z        = out_z_reg;
    assign m_out_size     = out_size_reg;
    assign m_out_color    = out_col_reg;
    assign m_out_spin     = out_spin_reg;
    assign m_last_of_tick = out_last_reg;
    assign m_none_alive   = out_none_reg;
    assign m_live_total   = out_total_reg;

endmodule

`default_nettype wire

// File: rtl/particle_pool_update.sv
// Top level of the particle pool: register port, controller and datapath.
//
//  Channel  | Direction | Handshake        | Carries
//  s_*      | in        | s_valid/s_ready  | spawn or tick item
//  m_*      | out       | m_valid/m_ready  | one surviving particle, or an empty tick marker
//  APB      | in        | psel/penable     | emitter settings, six registers
//
// A spawn gives no result and leaves the port ready; spawns may follow back to back.
// A tick runs a set-up, passes each dead or empty slot, ages and frees each slot that expires,
// and gives each survivor age, six products, the 2-bit/cycle divider tail, five lerp products
// and the hand-off, then a closing step; the walk waits only while the result side stalls.
// A further item is refused until the tick's closing result has entered the result register.
// The result register and one pending survivor let the walk run on while m_ready is low.
// Reset is synchronous, active low; no clearing pass is needed.
`default_nettype none
`include "particle_pool_update_macros.svh"

module particle_pool_update
    import ppu_pkg::*;
#(
    parameter int POOL_DEPTH = 64
)(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_mode,
    input  wire logic [POS_W-1:0]  s_spawn_x,
    input  wire logic [POS_W-1:0]  s_spawn_y,
    input  wire logic [POS_W-1:0]  s_spawn_z,
    input  wire logic [POS_W-1:0]  s_launch_vx,
    input  wire logic [POS_W-1:0]  s_launch_vy,
    input  wire logic [POS_W-1:0]  s_launch_vz,
    input  wire logic [SPIN_W-1:0] s_spin_angle,
    input  wire logic [AGE_W-1:0]  s_life_span,
    input  wire logic [DT_W-1:0]   s_time_step,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [POS_W-1:0]       m_out_x,
    output logic [POS_W-1:0]       m_out_y,
    output logic [POS_W-1:0]       m_out_z,
    output logic [SIZE_W-1:0]      m_out_size,
    output logic [COL_W-1:0]       m_out_color,
    output logic [SPIN_W-1:0]      m_out_spin,
    output logic                   m_last_of_tick,
    output logic                   m_none_alive,
    output logic [CNT_W-1:0]       m_live_total,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    ppu_cfg_t  cfg_reg;
    ppu_cmd_t  cmd;
    ppu_stat_t stat;
    logic      wr_strobe;
    logic [2:0] reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign wr_strobe = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{gravity_y:   RST_GRAVITY,
                         drag_rate:   RST_DRAG,
                         size_start:  RST_SIZE_START,
                         size_end:    RST_SIZE_END,
                         color_start: RST_COLOR_START,
                         color_end:   RST_COLOR_END};
        end else if (wr_strobe) begin
            case (reg_idx)
                REG_GRAVITY:     cfg_reg.gravity_y   <= pwdata;
                REG_DRAG:        cfg_reg.drag_rate   <= pwdata[AGE_W-1:0];
                REG_SIZE_START:  cfg_reg.size_start  <= pwdata[SIZE_W-1:0];
                REG_SIZE_END:    cfg_reg.size_end    <= pwdata[SIZE_W-1:0];
                REG_COLOR_START: cfg_reg.color_start <= pwdata;
                REG_COLOR_END:   cfg_reg.color_end   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GRAVITY:     prdata = cfg_reg.gravity_y;
            REG_DRAG:        prdata = {{(DATA_W - AGE_W){1'b0}}, cfg_reg.drag_rate};
            REG_SIZE_START:  prdata = {{(DATA_W - SIZE_W){1'b0}}, cfg_reg.size_start};
            REG_SIZE_END:    prdata = {{(DATA_W - SIZE_W){1'b0}}, cfg_reg.size_end};
            REG_COLOR_START: prdata = cfg_reg.color_start;
            REG_COLOR_END:   prdata = cfg_reg.color_end;
            default:         prdata = '0;
        endcase
    end

    ppu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ppu_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .stat           (stat),
        .s_spawn_x      (s_spawn_x),
        .s_spawn_y      (s_spawn_y),
        .s_spawn_z      (s_spawn_z),
        .s_launch_vx    (s_launch_vx),
        .s_launch_vy    (s_launch_vy),
        .s_launch_vz    (s_launch_vz),
        .s_spin_angle   (s_spin_angle),
        .s_life_span    (s_life_span),
        .s_time_step    (s_time_step),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_out_z        (m_out_z),
        .m_out_size     (m_out_size),
        .m_out_color    (m_out_color),
        .m_out_spin     (m_out_spin),
        .m_last_of_tick (m_last_of_tick),
        .m_none_alive   (m_none_alive),
        .m_live_total   (m_live_total)
    );

    `PPU_ASSERT_NOW(a_no_input_during_results, m_valid && !m_last_of_tick, !s_ready, "item taken mid-tick")
    `PPU_ASSERT_NOW(a_empty_is_last, m_valid && m_none_alive, m_last_of_tick && (m_live_total == '0), "bad empty marker")
    `PPU_ASSERT_NEXT(a_cfg_idle, wr_strobe, s_ready || $past(s_ready), "register written while busy")

endmodule

`default_nettype wire

// File: test/particle_pool_update_tb.sv
// Self-checking testbench for the particle pool: directed table, random traffic and predictor.
`default_nettype none

module particle_pool_update_tb
    import ppu_pkg::*;
;

    localparam int DEPTH = 64;
    localparam int N_RAND = 210;
    localparam int N_DIR = 20;
    localparam logic [2:0] REG_UNUSED = 3'd6;

    typedef struct packed {
        logic        mode;
        logic [31:0] px, py, pz, vx, vy, vz;
        logic [15:0] spin;
        logic [23:0] life;
        logic [15:0] dt;
    } item_t;

    typedef struct packed {
        logic [31:0] x, y, z;
        logic [15:0] size;
        logic [31:0] color;
        logic [15:0] spin;
        logic        last;
        logic        none;
        logic [6:0]  total;
    } particle_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    item_t cur = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [31:0] o_x, o_y, o_z, o_color;
    logic [15:0] o_size, o_spin;
    logic o_last, o_none;
    logic [6:0] o_total;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    particle_pool_update dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(cur.mode),
        .s_spawn_x(cur.px), .s_spawn_y(cur.py), .s_spawn_z(cur.pz),
        .s_launch_vx(cur.vx), .s_launch_vy(cur.vy), .s_launch_vz(cur.vz),
        .s_spin_angle(cur.spin), .s_life_span(cur.life), .s_time_step(cur.dt),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(o_x), .m_out_y(o_y), .m_out_z(o_z), .m_out_size(o_size),
        .m_out_color(o_color), .m_out_spin(o_spin), .m_last_of_tick(o_last),
        .m_none_alive(o_none), .m_live_total(o_total),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow of the emitter settings and of the pool.
    logic signed [31:0] sh_gravity;
    logic [23:0] sh_drag;
    logic [15:0] sh_size0, sh_size1;
    logic [31:0] sh_col0, sh_col1;
    logic        pool_alive [DEPTH];
    logic signed [31:0] pool_pos [DEPTH][3];
    logic signed [31:0] pool_vel [DEPTH][3];
    logic [23:0] pool_age [DEPTH];
    logic [23:0] pool_life [DEPTH];
    logic [15:0] pool_spin [DEPTH];
    int unsigned write_slot;

    particle_out_t pending_out[$];
    int errors = 0;
    int mismatches = 0;
    int hold_req = 0;

    function automatic longint floor16(longint v);
        return v >>> 16;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [16:0] t);
        longint d;
        d = longint'(b) - longint'(a);
        return 32'(longint'(a) + floor16(d * longint'(t)));
    endfunction

    function automatic void queue_result(particle_out_t r);
        pending_out = {pending_out, r};
    endfunction

    task automatic apply_item(input item_t it);
        int n;
        logic [24:0] age;
        longint f;
        logic signed [31:0] v;
        logic [16:0] t;
        particle_out_t r;
        if (it.mode == MODE_SPAWN) begin
            pool_pos[write_slot] = '{it.px, it.py, it.pz};
            pool_vel[write_slot] = '{it.vx, it.vy, it.vz};
            pool_spin[write_slot] = it.spin;
            pool_life[write_slot] = it.life;
            pool_age[write_slot] = '0;
            pool_alive[write_slot] = 1'b1;
            write_slot = (write_slot + 1) % DEPTH;
            return;
        end
        n = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (!pool_alive[i]) continue;
            age = {1'b0, pool_age[i]} + it.dt;
            if (age[24]) age = 25'hFFFFFF;
            pool_age[i] = age[23:0];
            if (age[23:0] >= pool_life[i]) begin
                pool_alive[i] = 1'b0;
                continue;
            end
            pool_vel[i][1] = clip32(longint'(pool_vel[i][1]) +
                                    floor16(longint'(sh_gravity) * longint'(it.dt)));
            f = 65536 - ((longint'(sh_drag) * longint'(it.dt)) >> 16);
            if (f < 0) f = 0;
            for (int k = 0; k < 3; k++) begin
                v = 32'(floor16(longint'(pool_vel[i][k]) * f));
                pool_vel[i][k] = v;
                pool_pos[i][k] = clip32(longint'(pool_pos[i][k]) +
                                        floor16(longint'(v) * longint'(it.dt)));
            end
            t = 17'((longint'(age[23:0]) << 16) / longint'(pool_life[i]));
            r = '0;
            r.x = pool_pos[i][0];
            r.y = pool_pos[i][1];
            r.z = pool_pos[i][2];
            r.size = 16'(blend(sh_size0, sh_size1, t));
            for (int s = 0; s < 32; s += 8)
                r.color[s +: 8] = 8'(blend(sh_col0[s +: 8], sh_col1[s +: 8], t));
            r.spin = pool_spin[i];
            queue_result(r);
            n++;
        end
        if (n == 0) begin
            r = '0;
            r.last = 1'b1;
            r.none = 1'b1;
            queue_result(r);
        end else begin
            pending_out[$].last = 1'b1;
            pending_out[$].total = 7'(n);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_GRAVITY:     sh_gravity = val;
            REG_DRAG:        sh_drag = val[23:0];
            REG_SIZE_START:  sh_size0 = val[15:0];
            REG_SIZE_END:    sh_size1 = val[15:0];
            REG_COLOR_START: sh_col0 = val;
            REG_COLOR_END:   sh_col1 = val;
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Valid stays high after a transfer so that the next item can follow at once.
    task automatic send(input item_t it);
        @(negedge aclk);
        cur <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_item(it);
    endtask

    task automatic stop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_edge32();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'(int'($urandom_range(0, 200000)) - 100000);
            default: return $urandom();
        endcase
    endfunction

    function automatic item_t rand_spawn();
        item_t it;
        it.mode = MODE_SPAWN;
        it.px = rand_edge32(); it.py = rand_edge32(); it.pz = rand_edge32();
        it.vx = rand_edge32(); it.vy = rand_edge32(); it.vz = rand_edge32();
        it.spin = 16'($urandom());
        // Mostly lifetimes of a few ticks, sometimes zero or the largest.
        case ($urandom_range(0, 9))
            0: it.life = 24'h0;
            1: it.life = 24'hFFFFFF;
            2: it.life = 24'($urandom());
            default: it.life = 24'($urandom_range(1, 4 * 65536));
        endcase
        it.dt = 16'($urandom());
        return it;
    endfunction

    function automatic item_t rand_tick();
        item_t it;
        it = rand_spawn();
        it.mode = MODE_TICK;
        case ($urandom_range(0, 7))
            0: it.dt = 16'hFFFF;
            1: it.dt = 16'h0;
            default: it.dt = 16'($urandom_range(1, 20000));
        endcase
        return it;
    endfunction

    // Result checker.
    always @(posedge aclk) begin
        particle_out_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{o_x, o_y, o_z, o_size, o_color, o_spin, o_last, o_none, o_total};
            if (pending_out.size() == 0) begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected transfer %h", got);
                mismatches++;
            end else begin
                want = pending_out.pop_front();
                if (got !== want) begin
                    errors++;
                    if (mismatches < 10)
                        $display("mismatch: exp x=%h y=%h z=%h sz=%h c=%h sp=%h l=%b n=%b t=%0d\n"
                                 , want.x, want.y, want.z, want.size, want.color, want.spin,
                                 want.last, want.none, want.total,
                                 "          got x=%h y=%h z=%h sz=%h c=%h sp=%h l=%b n=%b t=%0d",
                                 got.x, got.y, got.z, got.size, got.color, got.spin,
                                 got.last, got.none, got.total);
                    mismatches++;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial begin
        int stall;
        int hold_seen;
        hold_seen = 0;
        while (1) begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            stall = $urandom_range(0, 15);
            if (stall < 3) m_ready <= 1'b0;
            else m_ready <= 1'b1;
        end
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    item_t directed [N_DIR];

    initial begin
        item_t it;
        int burst;
        bit held;
        bit paused;
        sh_gravity = RST_GRAVITY;
        sh_drag = RST_DRAG;
        sh_size0 = RST_SIZE_START;
        sh_size1 = RST_SIZE_END;
        sh_col0 = RST_COLOR_START;
        sh_col1 = RST_COLOR_END;
        for (int i = 0; i < DEPTH; i++) begin
            pool_alive[i] = 1'b0;
            pool_age[i] = '0;
            pool_life[i] = '0;
        end
        write_slot = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Tick on an empty pool, zero lifetime, field extremes, zero and largest dt.
        directed[0] = '{MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF};
        directed[1] = '{MODE_SPAWN, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                        32'h8000_0000, 0, 16'hFFFF, 24'h0, 0};
        directed[2] = '{MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0};
        directed[3] = '{MODE_SPAWN, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0,
                        24'hFFFFFF, 16'hFFFF};
        directed[4] = '{MODE_SPAWN, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000,
                        32'h0, 32'h0, 16'h1234, 24'h02_0000, 0};
        for (int i = 5; i < N_DIR; i++) directed[i] = (i % 3 == 0) ? rand_tick() : rand_spawn();
        directed[N_DIR - 1].dt = 16'hFFFF;
        directed[N_DIR - 1].mode = MODE_TICK;
        for (int i = 0; i < N_DIR; i++) begin
            send(directed[i]);
            if (i == 0) begin
                // An empty pool gives the lone marker transfer.
                if (pending_out.size() != 1 || pending_out[0] !== particle_out_t'(
                        {32'h0, 32'h0, 32'h0, 16'h0, 32'h0, 16'h0, 1'b1, 1'b1, 7'h0})) begin
                    errors++;
                    $display("empty tick prediction wrong");
                end
            end
        end
        stop_valid();
        drain();

        // Settings phases: extremes first, then random values; an unused index is ignored.
        for (int ph = 0; ph < 4; ph++) begin
            held = 1'b0;
            paused = 1'b0;
            case (ph)
                0: begin
                    write_reg(REG_GRAVITY, 32'h8000_0000);
                    write_reg(REG_DRAG, 32'h00FF_FFFF);
                    write_reg(REG_SIZE_START, 32'h0000_FFFF);
                    write_reg(REG_SIZE_END, 32'h0);
                    write_reg(REG_COLOR_START, 32'h0);
                    write_reg(REG_COLOR_END, 32'hFFFF_FFFF);
                end
                1: begin
                    write_reg(REG_GRAVITY, 32'h7FFF_FFFF);
                    write_reg(REG_DRAG, 32'h0);
                    write_reg(REG_SIZE_START, 32'h0);
                    write_reg(REG_SIZE_END, 32'h0000_FFFF);
                    write_reg(REG_COLOR_START, 32'hFFFF_FFFF);
                    write_reg(REG_COLOR_END, 32'h0);
                    write_reg(REG_UNUSED, $urandom());
                end
                default: begin
                    write_reg(REG_GRAVITY, 32'(int'($urandom_range(0, 2000000)) - 1000000));
                    write_reg(REG_DRAG, $urandom_range(0, 200000));
                    write_reg(REG_SIZE_START, $urandom());
                    write_reg(REG_SIZE_END, $urandom());
                    write_reg(REG_COLOR_START, $urandom());
                    write_reg(REG_COLOR_END, $urandom());
                end
            endcase
            for (int n = 0; n < N_RAND / 4; ) begin
                burst = $urandom_range(1, 12);
                // One burst per phase goes out while the receiver is held off.
                if (!held && n >= 10) begin
                    held = 1'b1;
                    hold_req++;
                end
                for (int b = 0; b < burst && n < N_RAND / 4; b++, n++) begin
                    it = ($urandom_range(0, 3) == 0) ? rand_tick() : rand_spawn();
                    send(it);
                end
                stop_valid();
                if ($urandom_range(0, 1)) repeat ($urandom_range(1, 30)) @(posedge aclk);
                if (!paused && n >= 30) begin
                    paused = 1'b1;
                    while (pending_out.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end

        repeat (2000) @(posedge aclk);
        if (errors == 0 && pending_out.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
